// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold at every clock edge out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true at a clock edge out of reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/bcbr_pkg.sv =====
// ---------------------------------------------------------------------------
// bcbr_pkg
// Types, constants and helpers shared by the bounds-checked byte RAM.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcbr_pkg;

  localparam int DEF_STORE_BYTES = 65536;
  localparam int LANES           = 8;
  localparam int LANE_W          = 3;
  localparam int DATA_W          = 64;
  localparam int SIZE_W          = 17;
  localparam int CFG_ADDR_W      = 4;
  localparam int CFG_IDX_LSB     = 3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 17'h10000;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic {
    REG_BASE = 1'b0,
    REG_SIZE = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACC_1B = 2'd0,
    ACC_2B = 2'd1,
    ACC_4B = 2'd2,
    ACC_8B = 2'd3
  } acc_size_t;

  typedef struct packed {
    logic              ok;
    logic [LANE_W-1:0] lane;
    logic [LANES-1:0]  byte_en;
  } acc_ctl_t;

  function automatic logic [LANES-1:0] size_mask(input logic [1:0] acc_size);
    logic [LANES-1:0] m;
    case (acc_size_t'(acc_size))
      ACC_1B:  m = 8'h01;
      ACC_2B:  m = 8'h03;
      ACC_4B:  m = 8'h0f;
      ACC_8B:  m = 8'hff;
      default: m = 8'h01;
    endcase
    return m;
  endfunction

  function automatic logic [SIZE_W-1:0] size_bytes(input logic [1:0] acc_size);
    logic [SIZE_W-1:0] n;
    case (acc_size_t'(acc_size))
      ACC_1B:  n = SIZE_W'(1);
      ACC_2B:  n = SIZE_W'(2);
      ACC_4B:  n = SIZE_W'(4);
      ACC_8B:  n = SIZE_W'(8);
      default: n = SIZE_W'(1);
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bcbr_ram.sv =====
// ---------------------------------------------------------------------------
// bcbr_ram
// Generic single-port RAM with write enable and a registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                                   clk,
  input  wire logic                                   en,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                       wdata,
  output      logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end
      rdata <= mem_r[addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bcbr_cfg.sv =====
// ---------------------------------------------------------------------------
// bcbr_cfg
// Register file for the mapped region: base address and size.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcbr_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [bcbr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [bcbr_pkg::DATA_W-1:0]      pwdata,
  output      logic [bcbr_pkg::DATA_W-1:0]      prdata,
  output      logic                             pready,
  output      logic [bcbr_pkg::DATA_W-1:0]      region_base,
  output      logic [bcbr_pkg::SIZE_W-1:0]      region_size
);

  logic [bcbr_pkg::DATA_W-1:0] base_r;
  logic [bcbr_pkg::SIZE_W-1:0] size_r;
  bcbr_pkg::reg_idx_t          idx;
  logic                        wr;

  assign pready = 1'b1;
  assign idx    = bcbr_pkg::reg_idx_t'(paddr[bcbr_pkg::CFG_IDX_LSB]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      size_r <= bcbr_pkg::SIZE_RESET;
    end else if (wr) begin
      case (idx)
        bcbr_pkg::REG_BASE: base_r <= pwdata;
        bcbr_pkg::REG_SIZE: size_r <= pwdata[bcbr_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bcbr_pkg::REG_BASE: prdata = base_r;
      bcbr_pkg::REG_SIZE: prdata = bcbr_pkg::DATA_W'(size_r);
      default:            prdata = '0;
    endcase
  end

  assign region_base = base_r;
  assign region_size = size_r;

endmodule

`default_nettype wire

// ===== hw/rtl/bcbr_check.sv =====
// ---------------------------------------------------------------------------
// bcbr_check
// Wrap-safe bounds check of one access and its split over the byte banks.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcbr_check #(
  parameter int STORE_BYTES = bcbr_pkg::DEF_STORE_BYTES
) (
  input  wire logic [bcbr_pkg::DATA_W-1:0] address,
  input  wire logic [1:0]                  access_size,
  input  wire logic [bcbr_pkg::DATA_W-1:0] region_base,
  input  wire logic [bcbr_pkg::SIZE_W-1:0] region_size,
  output      bcbr_pkg::acc_ctl_t          ctl,
  output      logic [((STORE_BYTES > 8) ? $clog2(STORE_BYTES) - 3 : 1)-1:0] row
);

  localparam int SZW   = ($clog2(STORE_BYTES + 1) > bcbr_pkg::SIZE_W) ?
                         $clog2(STORE_BYTES + 1) : bcbr_pkg::SIZE_W;
  localparam int ROW_W = (STORE_BYTES > 8) ? $clog2(STORE_BYTES) - 3 : 1;

  logic [bcbr_pkg::DATA_W:0]   diff;
  logic [bcbr_pkg::DATA_W-1:0] off;
  logic                        below;
  logic [SZW-1:0]              size_ext;
  logic [SZW-1:0]              size_sat;
  logic [SZW-1:0]              nbytes;
  logic                        off_high;
  logic                        fits;

  assign diff     = {1'b0, address} - {1'b0, region_base};
  assign below    = diff[bcbr_pkg::DATA_W];
  assign off      = diff[bcbr_pkg::DATA_W-1:0];
  assign size_ext = SZW'(region_size);
  assign size_sat = (size_ext > SZW'(STORE_BYTES)) ? SZW'(STORE_BYTES) : size_ext;
  assign nbytes   = SZW'(bcbr_pkg::size_bytes(access_size));
  assign off_high = |(off >> SZW);
  assign fits     = (nbytes <= size_sat) && (off[SZW-1:0] <= (size_sat - nbytes));

  assign ctl.ok      = !below && !off_high && fits;
  assign ctl.lane    = off[bcbr_pkg::LANE_W-1:0];
  assign ctl.byte_en = bcbr_pkg::size_mask(access_size);
  assign row         = ROW_W'(off >> bcbr_pkg::LANE_W);

endmodule

`default_nettype wire

// ===== hw/rtl/bcbr_gather.sv =====
// ---------------------------------------------------------------------------
// bcbr_gather
// Rotates bank read data into little-endian order and masks it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcbr_gather (
  input  wire logic                               opcode,
  input  wire bcbr_pkg::acc_ctl_t                 ctl,
  input  wire logic [bcbr_pkg::LANES-1:0][7:0]    bank_rdata,
  output      logic [bcbr_pkg::DATA_W-1:0]        read_data
);

  logic [bcbr_pkg::LANES-1:0][7:0] bytes;
  logic                            keep;

  assign keep = ctl.ok && (bcbr_pkg::op_t'(opcode) == bcbr_pkg::OP_READ);

  always_comb begin
    for (int b = 0; b < bcbr_pkg::LANES; b++) begin
      if (keep && ctl.byte_en[b]) begin
        bytes[b] = bank_rdata[bcbr_pkg::LANE_W'(ctl.lane + bcbr_pkg::LANE_W'(b))];
      end else begin
        bytes[b] = 8'h00;
      end
    end
  end

  assign read_data = bytes;

endmodule

`default_nettype wire

// ===== hw/rtl/bounds_checked_byte_ram.sv =====
// ---------------------------------------------------------------------------
// bounds_checked_byte_ram
// Little-endian byte-addressed RAM with a bounds check against a
// configurable region, sticky fault flag and recorded fault address.
// ---------------------------------------------------------------------------
//
//   channel  direction  handshake         payload
//   in_      sink       in_valid/in_stall opcode, address, access_size, write_data
//   out_     source     out_valid/out_stall read_data, fault_now, fault_seen,
//                                         fault_address
//   cfg      APB slave  psel/penable      region_base, region_size
//
// One beat is accepted per cycle while in_stall is low; its result passes the s1 and s2 registers and is
// offered from the output register. Eight byte-wide banks serve any unaligned access of up to eight bytes at once.
// After reset a clearing pass zeroes one row of every bank per cycle,
// through all ROWS rows, while the input stays stalled.
// A stalled output holds its beat, and the stages behind it fill up
// before in_stall is raised.
//
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bounds_checked_byte_ram #(
  parameter int STORE_BYTES = bcbr_pkg::DEF_STORE_BYTES
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output      logic                             in_stall,
  input  wire logic                             in_opcode,
  input  wire logic [63:0]                      in_address,
  input  wire logic [1:0]                       in_access_size,
  input  wire logic [63:0]                      in_write_data,
  output      logic                             out_valid,
  input  wire logic                             out_stall,
  output      logic [63:0]                      out_read_data,
  output      logic                             out_fault_now,
  output      logic                             out_fault_seen,
  output      logic [63:0]                      out_fault_address,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [bcbr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [63:0]                      pwdata,
  output      logic [63:0]                      prdata,
  output      logic                             pready
);

  localparam int LANES = bcbr_pkg::LANES;
  localparam int LW    = bcbr_pkg::LANE_W;
  localparam int ROWS  = (STORE_BYTES + LANES - 1) / LANES;
  localparam int ROW_W = (STORE_BYTES > 8) ? $clog2(STORE_BYTES) - 3 : 1;

  logic [63:0]               region_base;
  logic [bcbr_pkg::SIZE_W-1:0] region_size;

  logic                      clearing_r;
  logic [ROW_W-1:0]          clr_row_r;

  logic                      s1_v_r;
  logic                      s1_op_r;
  logic [63:0]               s1_addr_r;
  logic [1:0]                s1_size_r;
  logic [LANES-1:0][7:0]     s1_wdata_r;

  logic                      s2_v_r;
  logic                      s2_op_r;
  bcbr_pkg::acc_ctl_t        s2_ctl_r;
  logic                      s2_seen_r;
  logic [63:0]               s2_faddr_r;

  logic                      out_valid_r;
  logic [63:0]               out_rdata_r;
  logic                      out_fnow_r;
  logic                      out_seen_r;
  logic [63:0]               out_faddr_r;

  logic                      fault_seen_r;
  logic                      fault_seen_nxt;
  logic [63:0]               fault_addr_r;
  logic [63:0]               fault_addr_nxt;

  bcbr_pkg::acc_ctl_t        s1_ctl;
  logic [ROW_W-1:0]          s1_row;
  logic                      s3_rdy;
  logic                      s2_adv;
  logic                      mv12;
  logic                      acc;
  logic                      wr_ok;

  logic [LANES-1:0]          bank_en;
  logic [LANES-1:0]          bank_we;
  logic [ROW_W-1:0]          bank_addr [LANES];
  logic [7:0]                bank_wdata [LANES];
  logic [LANES-1:0][7:0]     bank_rdata;
  logic [63:0]               gather_data;

  bcbr_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .region_base (region_base),
    .region_size (region_size)
  );

  bcbr_check #(.STORE_BYTES(STORE_BYTES)) u_check (
    .address     (s1_addr_r),
    .access_size (s1_size_r),
    .region_base (region_base),
    .region_size (region_size),
    .ctl         (s1_ctl),
    .row         (s1_row)
  );

  assign s3_rdy   = !out_valid_r || !out_stall;
  assign s2_adv   = !s2_v_r || s3_rdy;
  assign mv12     = s1_v_r && s2_adv;
  assign in_stall = clearing_r || (s1_v_r && !s2_adv);
  assign acc      = in_valid && !in_stall;
  assign wr_ok    = mv12 && s1_ctl.ok && (bcbr_pkg::op_t'(s1_op_r) == bcbr_pkg::OP_WRITE);

  always_comb begin
    fault_seen_nxt = fault_seen_r;
    fault_addr_nxt = fault_addr_r;
    if (mv12 && !s1_ctl.ok) begin
      fault_seen_nxt = 1'b1;
      fault_addr_nxt = s1_addr_r;
    end
  end

  // Bank k holds the byte of this access whose index is k minus the lane.
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      if (clearing_r) begin
        bank_en[k]    = 1'b1;
        bank_we[k]    = 1'b1;
        bank_addr[k]  = clr_row_r;
        bank_wdata[k] = 8'h00;
      end else begin
        bank_en[k]    = mv12;
        bank_we[k]    = wr_ok && s1_ctl.byte_en[LW'(LW'(k) - s1_ctl.lane)];
        bank_addr[k]  = s1_row + ROW_W'(LW'(k) < s1_ctl.lane);
        bank_wdata[k] = s1_wdata_r[LW'(LW'(k) - s1_ctl.lane)];
      end
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_bank
    bcbr_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
      .clk   (clk),
      .en    (bank_en[k]),
      .we    (bank_we[k]),
      .addr  (bank_addr[k]),
      .wdata (bank_wdata[k]),
      .rdata (bank_rdata[k])
    );
  end

  bcbr_gather u_gather (
    .opcode     (s2_op_r),
    .ctl        (s2_ctl_r),
    .bank_rdata (bank_rdata),
    .read_data  (gather_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r   <= 1'b1;
      clr_row_r    <= '0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      fault_seen_r <= 1'b0;
      fault_addr_r <= '0;
    end else begin
      if (clearing_r) begin
        clr_row_r <= clr_row_r + ROW_W'(1);
        if (clr_row_r == ROW_W'(ROWS - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (acc) begin
        s1_v_r <= 1'b1;
      end else if (mv12) begin
        s1_v_r <= 1'b0;
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_rdy) begin
        out_valid_r <= s2_v_r;
      end
      fault_seen_r <= fault_seen_nxt;
      fault_addr_r <= fault_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_op_r    <= in_opcode;
      s1_addr_r  <= in_address;
      s1_size_r  <= in_access_size;
      s1_wdata_r <= in_write_data;
    end
    if (mv12) begin
      s2_op_r    <= s1_op_r;
      s2_ctl_r   <= s1_ctl;
      s2_seen_r  <= fault_seen_nxt;
      s2_faddr_r <= fault_addr_nxt;
    end
    if (s2_v_r && s3_rdy) begin
      out_rdata_r <= gather_data;
      out_fnow_r  <= !s2_ctl_r.ok;
      out_seen_r  <= s2_seen_r;
      out_faddr_r <= s2_faddr_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_rdata_r;
  assign out_fault_now     = out_fnow_r;
  assign out_fault_seen    = out_seen_r;
  assign out_fault_address = out_faddr_r;

  `ASSERT_CLK(a_fault_sets_flag, (mv12 && !s1_ctl.ok) |=> fault_seen_r, "fault not recorded")
  `ASSERT_CLK(a_flag_sticky, fault_seen_r |=> fault_seen_r, "sticky fault flag cleared")
  `ASSERT_CLK(a_fault_flag, (out_valid && out_fault_now) |-> out_fault_seen, "flag not set")
  `ASSERT_CLK(a_fault_data, (out_valid && out_fault_now) |-> out_read_data == 64'd0, "data on fault")
  `ASSERT_NEVER(a_clear_empty, clearing_r && (s1_v_r || s2_v_r), "beat during clearing")

endmodule

`default_nettype wire
